// ===== rtl/core/sacc_pkg.sv =====
// ----------------------------------------------------------------------------
// sacc_pkg
// Shared geometry, codes and helpers of the set-associative LRU cache
// controller.
// ----------------------------------------------------------------------------
package sacc_pkg;

    localparam int LINE_BYTES = 32;
    localparam int SET_COUNT  = 64;
    localparam int WAY_COUNT  = 4;

    localparam int ADDR_W    = 32;
    localparam int WORD_W    = 32;
    localparam int OFF_W     = $clog2(LINE_BYTES);
    localparam int SET_W     = $clog2(SET_COUNT);
    localparam int WAY_W     = $clog2(WAY_COUNT);
    localparam int TAG_W     = ADDR_W - OFF_W - SET_W;
    localparam int WPL       = LINE_BYTES / 4;
    localparam int WSEL_W    = $clog2(WPL);
    localparam int LINES     = SET_COUNT * WAY_COUNT;
    localparam int LINE_W    = SET_W + WAY_W;
    localparam int STAMP_W   = 32;
    localparam int ENTRY_W   = TAG_W + STAMP_W;
    localparam int ROW_W     = ENTRY_W * WAY_COUNT;
    localparam int DDEPTH    = LINES * WPL;
    localparam int CNT_W     = WSEL_W + 1;
    localparam int PEN_W     = 16;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_STORE  = 2'd1;
    localparam logic [1:0] CMD_REFILL = 2'd2;
    localparam logic [1:0] CMD_INVAL  = 2'd3;

    localparam logic [2:0] KIND_RESP    = 3'd0;
    localparam logic [2:0] KIND_WB      = 3'd1;
    localparam logic [2:0] KIND_LINE_RD = 3'd2;
    localparam logic [2:0] KIND_WORD_RD = 3'd3;
    localparam logic [2:0] KIND_MEM_WR  = 3'd4;

    localparam logic [1:0] CFG_WB_MODE = 2'd0;
    localparam logic [1:0] CFG_ALLOC   = 2'd1;
    localparam logic [1:0] CFG_PENALTY = 2'd2;

    typedef enum logic [1:0] {
        P_NONE,
        P_LOAD,
        P_BYPASS,
        P_STORE
    } t_pend;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAG,
        S_DRD0,
        S_DRD1,
        S_DRD2,
        S_UPD,
        S_UPD2,
        S_MWR,
        S_RESP,
        S_WRQ,
        S_WRQ2,
        S_WBRD,
        S_WBOUT,
        S_LREQ
    } t_state;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic [WAY_W-1:0] victim;
    } t_lookup;

    function automatic logic [2:0] size_bytes(input logic [1:0] sz);
        logic [2:0] nb;
        nb = sz[1] ? 3'd4 : (sz[0] ? 3'd2 : 3'd1);
        return nb;
    endfunction

    function automatic logic [WORD_W-1:0] byte_mask(input logic [2:0] nb);
        logic [WORD_W-1:0] m;
        m = (nb == 3'd4) ? 32'hffff_ffff : ((nb == 3'd2) ? 32'h0000_ffff : 32'h0000_00ff);
        return m;
    endfunction

endpackage

// ===== rtl/core/sacc_ram.sv =====
// ----------------------------------------------------------------------------
// sacc_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sacc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sacc_way_sel.sv =====
// ----------------------------------------------------------------------------
// sacc_way_sel
// Tag compare and victim choice over one set: first invalid way, otherwise
// the way with the oldest stamp.
// ----------------------------------------------------------------------------
module sacc_way_sel (
    input  logic [sacc_pkg::ROW_W-1:0]     i_row,
    input  logic [sacc_pkg::WAY_COUNT-1:0] i_way_valid,
    input  logic [sacc_pkg::TAG_W-1:0]     i_tag,
    output sacc_pkg::t_lookup              o_look
);

    always_comb begin
        logic                              found_hit;
        logic                              found_inv;
        logic [sacc_pkg::STAMP_W-1:0]      best;
        logic [sacc_pkg::WAY_W-1:0]        lru_way;
        logic [sacc_pkg::ENTRY_W-1:0]      ent;
        found_hit = 1'b0;
        found_inv = 1'b0;
        o_look    = '0;
        lru_way   = '0;
        best      = i_row[sacc_pkg::TAG_W +: sacc_pkg::STAMP_W];
        for (int w = 0; w < sacc_pkg::WAY_COUNT; w++) begin
            ent = i_row[w*sacc_pkg::ENTRY_W +: sacc_pkg::ENTRY_W];
            if (!found_hit && i_way_valid[w] && ent[sacc_pkg::TAG_W-1:0] == i_tag) begin
                found_hit      = 1'b1;
                o_look.hit_way = sacc_pkg::WAY_W'(w);
            end
            if (!found_inv && !i_way_valid[w]) begin
                found_inv     = 1'b1;
                o_look.victim = sacc_pkg::WAY_W'(w);
            end
            if (ent[sacc_pkg::ENTRY_W-1:sacc_pkg::TAG_W] < best) begin
                best    = ent[sacc_pkg::ENTRY_W-1:sacc_pkg::TAG_W];
                lru_way = sacc_pkg::WAY_W'(w);
            end
        end
        o_look.hit = found_hit;
        if (!found_inv) begin
            o_look.victim = lru_way;
        end
    end

endmodule

// ===== rtl/core/set_assoc_lru_cache_controller_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_controller_unit
// Set-associative cache controller, 4 ways x 64 sets x 32-byte lines, stamp
// LRU, write-back or write-through, optional write-allocate, bypass reads.
//
//   channel  direction  handshake           payload
//   in       sink       i_valid / o_stall   i_cmd i_access_size i_address
//                                           i_payload
//   out      source     o_valid / i_stall   o_kind o_mem_address o_mem_data
//                                           o_mem_bytes o_load_data o_latency
//                                           o_error o_last
//   cfg      sink       i_cfg_we            i_cfg_index i_cfg_data
//
// One transaction at a time. Invalidate and refill words other than the last
// are taken in the idle state; a hit steps through tag read, two data word
// reads, tag and data write-back through the single-port RAMs, then issues
// its results. A dirty victim adds a data RAM read per written-back word.
// Synchronous active-low reset; valid and dirty bits clear at once, no sweep.
// Results leave through one output register and wait there while stalled.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_address,
    input  logic [31:0] i_payload,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [31:0] o_mem_address,
    output logic [31:0] o_mem_data,
    output logic [2:0]  o_mem_bytes,
    output logic [31:0] o_load_data,
    output logic [15:0] o_latency,
    output logic        o_error,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int OW = sacc_pkg::OFF_W;
    localparam int SW = sacc_pkg::SET_W;
    localparam int AW = sacc_pkg::ADDR_W;

    sacc_pkg::t_state r_state, n_state;
    sacc_pkg::t_pend  r_pend;

    logic                          r_wb_mode, r_alloc;
    logic [sacc_pkg::PEN_W-1:0]    r_penalty;

    logic [sacc_pkg::LINES-1:0]    r_valid, r_dirty;
    logic [sacc_pkg::STAMP_W-1:0]  r_use;
    logic [sacc_pkg::CNT_W-1:0]    r_rcnt;
    logic [AW-1:0]                 r_paddr;
    logic [2:0]                    r_pnb;
    logic [31:0]                   r_pdata;
    logic [sacc_pkg::WAY_W-1:0]    r_pway;
    logic [31:0]                   r_bfirst;

    logic                          r_fin, r_store;
    logic [AW-1:0]                 r_addr;
    logic [2:0]                    r_nb;
    logic [31:0]                   r_d;
    logic [sacc_pkg::WAY_W-1:0]    r_way;
    logic [sacc_pkg::WSEL_W-1:0]   r_k;
    logic [sacc_pkg::TAG_W-1:0]    r_vtag;
    logic [sacc_pkg::ROW_W-1:0]    r_row;
    logic [31:0]                   r_w0, r_w1;
    logic [31:0]                   r_rld;
    logic [15:0]                   r_rlat;
    logic                          r_rerr;

    logic                          r_ov;
    logic [2:0]                    r_okind, r_obytes;
    logic [31:0]                   r_oaddr, r_odata, r_old;
    logic [15:0]                   r_olat;
    logic                          r_oerr, r_olast;

    // memory ports
    logic                          t_we, t_re;
    logic [SW-1:0]                 t_addr;
    logic [sacc_pkg::ROW_W-1:0]    t_wdata, t_rdata;
    logic                          d_we, d_re;
    logic [$clog2(sacc_pkg::DDEPTH)-1:0] d_addr;
    logic [31:0]                   d_wdata, d_rdata;

    // decisions
    logic                          acc, out_free, emit;
    logic [2:0]                    in_nb;
    logic                          in_cross, cpu_go, rf_fill, rf_last, byp_first;
    logic [OW-1:0]                 off;
    logic [SW-1:0]                 set_i;
    logic [sacc_pkg::TAG_W-1:0]    tag_i;
    logic [sacc_pkg::WSEL_W-1:0]   wi;
    logic [sacc_pkg::WAY_COUNT-1:0] set_valid;
    sacc_pkg::t_lookup             look;
    logic                          go_byp, go_hit, go_mwr, go_fill, vic_dirty;
    logic                          two_rd, span, allow;
    logic [63:0]                   win, new_win;
    logic [31:0]                   load_val;
    logic [15:0]                   byp_val;
    logic [31:0]                   byp_sh;
    logic [sacc_pkg::ROW_W-1:0]    new_row;
    logic [sacc_pkg::LINE_W-1:0]   cur_line, vic_line;

    logic [2:0]                    e_kind, e_bytes;
    logic [31:0]                   e_addr, e_data, e_ld;
    logic [15:0]                   e_lat;
    logic                          e_err, e_last;

    sacc_ram #(.WIDTH(sacc_pkg::ROW_W), .DEPTH(sacc_pkg::SET_COUNT)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_re    (t_re),
        .i_addr  (t_addr),
        .i_wdata (t_wdata),
        .o_rdata (t_rdata)
    );

    sacc_ram #(.WIDTH(32), .DEPTH(sacc_pkg::DDEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_re    (d_re),
        .i_addr  (d_addr),
        .i_wdata (d_wdata),
        .o_rdata (d_rdata)
    );

    sacc_way_sel u_way_sel (
        .i_row       (t_rdata),
        .i_way_valid (set_valid),
        .i_tag       (tag_i),
        .o_look      (look)
    );

    assign o_stall  = (r_state != sacc_pkg::S_IDLE);
    assign acc      = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;

    assign in_nb     = sacc_pkg::size_bytes(i_access_size);
    assign in_cross  = (in_nb == 3'd4) &&
                       (i_address[OW-1:0] > OW'(sacc_pkg::LINE_BYTES - 4));
    assign cpu_go    = (i_cmd == sacc_pkg::CMD_LOAD || i_cmd == sacc_pkg::CMD_STORE) &&
                       (r_pend == sacc_pkg::P_NONE);
    assign rf_fill   = (i_cmd == sacc_pkg::CMD_REFILL) &&
                       (r_pend == sacc_pkg::P_LOAD || r_pend == sacc_pkg::P_STORE);
    assign rf_last   = (r_rcnt == sacc_pkg::CNT_W'(sacc_pkg::WPL - 1));
    assign byp_first = (r_paddr[1:0] == 2'd3) && (r_rcnt == '0);

    assign byp_sh  = i_payload >> {r_paddr[1:0], 3'b000};
    assign byp_val = (r_paddr[1:0] == 2'd3) ? {i_payload[7:0], r_bfirst[31:24]}
                                            : byp_sh[15:0];

    assign off   = r_addr[OW-1:0];
    assign set_i = r_addr[OW +: SW];
    assign tag_i = r_addr[AW-1 -: sacc_pkg::TAG_W];
    assign wi    = off[OW-1:2];

    always_comb begin
        for (int w = 0; w < sacc_pkg::WAY_COUNT; w++) begin
            set_valid[w] = r_valid[{set_i, sacc_pkg::WAY_W'(w)}];
        end
    end

    assign vic_line  = {set_i, look.victim};
    assign cur_line  = {set_i, r_way};
    assign vic_dirty = r_valid[vic_line] && r_dirty[vic_line];

    // lookup outcome for a CPU transaction
    assign go_byp  = !r_store && (r_nb == 3'd2) &&
                     !(look.hit && off != OW'(sacc_pkg::LINE_BYTES - 1));
    assign go_hit  = !go_byp && look.hit;
    assign go_mwr  = r_store && !look.hit && (!r_wb_mode || !r_alloc);
    assign go_fill = !go_byp && !look.hit && !go_mwr;
    assign two_rd  = (r_addr[1:0] == 2'd3);

    assign span  = ({1'b0, r_addr[1:0]} + r_nb) > 3'd4;
    assign allow = ({1'b0, off} + {{(OW-2){1'b0}}, r_nb}) <= (OW+1)'(sacc_pkg::LINE_BYTES);

    assign win      = {r_w1, r_w0};
    assign load_val = 32'(win >> {r_addr[1:0], 3'b000}) & sacc_pkg::byte_mask(r_nb);
    assign new_win  = (win & ~({32'b0, sacc_pkg::byte_mask(r_nb)} << {r_addr[1:0], 3'b000})) |
                      ({32'b0, r_d} << {r_addr[1:0], 3'b000});

    always_comb begin
        new_row = r_row;
        new_row[r_way*sacc_pkg::ENTRY_W +: sacc_pkg::ENTRY_W] =
            {r_use + 32'd1,
             r_fin ? tag_i : r_row[r_way*sacc_pkg::ENTRY_W +: sacc_pkg::TAG_W]};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sacc_pkg::S_IDLE: begin
                if (acc) begin
                    if (cpu_go) begin
                        n_state = in_cross ? sacc_pkg::S_RESP : sacc_pkg::S_TAG;
                    end else if (rf_fill && rf_last) begin
                        n_state = sacc_pkg::S_TAG;
                    end else if (i_cmd == sacc_pkg::CMD_REFILL &&
                                 r_pend == sacc_pkg::P_BYPASS && !byp_first) begin
                        n_state = sacc_pkg::S_RESP;
                    end
                end
            end
            sacc_pkg::S_TAG: begin
                if (r_fin || go_hit) begin
                    n_state = sacc_pkg::S_DRD0;
                end else if (go_byp) begin
                    n_state = sacc_pkg::S_WRQ;
                end else if (go_mwr) begin
                    n_state = sacc_pkg::S_MWR;
                end else begin
                    n_state = vic_dirty ? sacc_pkg::S_WBRD : sacc_pkg::S_LREQ;
                end
            end
            sacc_pkg::S_DRD0: n_state = sacc_pkg::S_DRD1;
            sacc_pkg::S_DRD1: n_state = sacc_pkg::S_DRD2;
            sacc_pkg::S_DRD2: n_state = sacc_pkg::S_UPD;
            sacc_pkg::S_UPD:  n_state = sacc_pkg::S_UPD2;
            sacc_pkg::S_UPD2: begin
                n_state = (r_store && !r_fin && !r_wb_mode) ? sacc_pkg::S_MWR
                                                            : sacc_pkg::S_RESP;
            end
            sacc_pkg::S_MWR: if (out_free) n_state = sacc_pkg::S_RESP;
            sacc_pkg::S_RESP: if (out_free) n_state = sacc_pkg::S_IDLE;
            sacc_pkg::S_WRQ: begin
                if (out_free) n_state = two_rd ? sacc_pkg::S_WRQ2 : sacc_pkg::S_IDLE;
            end
            sacc_pkg::S_WRQ2: if (out_free) n_state = sacc_pkg::S_IDLE;
            sacc_pkg::S_WBRD: n_state = sacc_pkg::S_WBOUT;
            sacc_pkg::S_WBOUT: begin
                if (out_free) begin
                    n_state = (r_k == sacc_pkg::WSEL_W'(sacc_pkg::WPL - 1)) ?
                              sacc_pkg::S_LREQ : sacc_pkg::S_WBRD;
                end
            end
            sacc_pkg::S_LREQ: if (out_free) n_state = sacc_pkg::S_IDLE;
            default: n_state = sacc_pkg::S_IDLE;
        endcase
    end

    // memory controls and results
    always_comb begin
        t_we = 1'b0; t_re = 1'b0; t_addr = set_i; t_wdata = new_row;
        d_we = 1'b0; d_re = 1'b0; d_addr = {cur_line, wi}; d_wdata = new_win[31:0];
        emit = 1'b0;
        e_kind = sacc_pkg::KIND_RESP; e_addr = '0; e_data = '0; e_bytes = '0;
        e_ld = '0; e_lat = '0; e_err = 1'b0; e_last = 1'b0;
        case (r_state)
            sacc_pkg::S_IDLE: begin
                if (acc && cpu_go && !in_cross) begin
                    t_re   = 1'b1;
                    t_addr = i_address[OW +: SW];
                end else if (acc && rf_fill) begin
                    d_we    = 1'b1;
                    d_addr  = {r_paddr[OW +: SW], r_pway, r_rcnt[sacc_pkg::WSEL_W-1:0]};
                    d_wdata = i_payload;
                    if (rf_last) begin
                        t_re   = 1'b1;
                        t_addr = r_paddr[OW +: SW];
                    end
                end
            end
            sacc_pkg::S_DRD0: d_re = 1'b1;
            sacc_pkg::S_DRD1: begin
                d_re   = 1'b1;
                d_addr = {cur_line, wi + 1'b1};
            end
            sacc_pkg::S_UPD: begin
                t_we = 1'b1;
                d_we = r_store && allow;
            end
            sacc_pkg::S_UPD2: begin
                d_we    = r_store && allow && span;
                d_addr  = {cur_line, wi + 1'b1};
                d_wdata = new_win[63:32];
            end
            sacc_pkg::S_WBRD: begin
                d_re   = 1'b1;
                d_addr = {cur_line, r_k};
            end
            sacc_pkg::S_MWR: begin
                emit    = out_free;
                e_kind  = sacc_pkg::KIND_MEM_WR;
                e_addr  = r_addr;
                e_data  = r_d;
                e_bytes = r_nb;
            end
            sacc_pkg::S_RESP: begin
                emit   = out_free;
                e_ld   = r_rld;
                e_lat  = r_rlat;
                e_err  = r_rerr;
                e_last = 1'b1;
            end
            sacc_pkg::S_WRQ: begin
                emit   = out_free;
                e_kind = sacc_pkg::KIND_WORD_RD;
                e_addr = {r_addr[AW-1:2], 2'b00};
                e_last = !two_rd;
            end
            sacc_pkg::S_WRQ2: begin
                emit   = out_free;
                e_kind = sacc_pkg::KIND_WORD_RD;
                e_addr = {r_addr[AW-1:2], 2'b00} + 32'd4;
                e_last = 1'b1;
            end
            sacc_pkg::S_WBOUT: begin
                emit   = out_free;
                e_kind = sacc_pkg::KIND_WB;
                e_addr = {r_vtag, set_i, r_k, 2'b00};
                e_data = d_rdata;
            end
            sacc_pkg::S_LREQ: begin
                emit   = out_free;
                e_kind = sacc_pkg::KIND_LINE_RD;
                e_addr = {r_addr[AW-1:OW], {OW{1'b0}}};
                e_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sacc_pkg::S_IDLE;
            r_pend    <= sacc_pkg::P_NONE;
            r_wb_mode <= 1'b0;
            r_alloc   <= 1'b0;
            r_penalty <= '0;
            r_valid   <= '0;
            r_dirty   <= '0;
            r_use     <= '0;
            r_rcnt    <= '0;
            r_paddr   <= '0;
            r_pdata   <= '0;
            r_pway    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sacc_pkg::CFG_WB_MODE: r_wb_mode <= i_cfg_data[0];
                    sacc_pkg::CFG_ALLOC:   r_alloc   <= i_cfg_data[0];
                    sacc_pkg::CFG_PENALTY: r_penalty <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                sacc_pkg::S_IDLE: begin
                    if (acc && i_cmd == sacc_pkg::CMD_INVAL) begin
                        r_valid <= '0;
                        r_dirty <= '0;
                        r_pend  <= sacc_pkg::P_NONE;
                        r_rcnt  <= '0;
                    end else if (acc && rf_fill) begin
                        r_rcnt <= r_rcnt + 1'b1;
                    end else if (acc && i_cmd == sacc_pkg::CMD_REFILL &&
                                 r_pend == sacc_pkg::P_BYPASS) begin
                        if (byp_first) begin
                            r_rcnt <= 4'd1;
                        end else begin
                            r_pend <= sacc_pkg::P_NONE;
                        end
                    end
                end
                sacc_pkg::S_TAG: begin
                    if (!r_fin && go_byp) begin
                        r_pend  <= sacc_pkg::P_BYPASS;
                        r_paddr <= r_addr;
                        r_rcnt  <= '0;
                    end else if (!r_fin && go_fill) begin
                        r_pend   <= r_store ? sacc_pkg::P_STORE : sacc_pkg::P_LOAD;
                        r_paddr  <= r_addr;
                        r_pdata  <= r_d;
                        r_pway   <= look.victim;
                        r_rcnt   <= '0;
                        r_valid[vic_line] <= 1'b0;
                        r_dirty[vic_line] <= 1'b0;
                    end
                end
                sacc_pkg::S_UPD: begin
                    r_use <= r_use + 32'd1;
                    if (r_fin) begin
                        r_valid[cur_line] <= 1'b1;
                        r_pend <= sacc_pkg::P_NONE;
                    end
                    if (r_store && (r_fin || r_wb_mode)) begin
                        r_dirty[cur_line] <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // transaction datapath
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_okind  <= e_kind;
            r_oaddr  <= e_addr;
            r_odata  <= e_data;
            r_obytes <= e_bytes;
            r_old    <= e_ld;
            r_olat   <= e_lat;
            r_oerr   <= e_err;
            r_olast  <= e_last;
        end
        case (r_state)
            sacc_pkg::S_IDLE: begin
                if (acc && cpu_go) begin
                    r_fin   <= 1'b0;
                    r_store <= (i_cmd == sacc_pkg::CMD_STORE);
                    r_addr  <= i_address;
                    r_nb    <= in_nb;
                    r_d     <= i_payload & sacc_pkg::byte_mask(in_nb);
                    r_rld   <= '0;
                    r_rlat  <= '0;
                    r_rerr  <= in_cross;
                end else if (acc && rf_fill) begin
                    if (rf_last) begin
                        r_fin   <= 1'b1;
                        r_store <= (r_pend == sacc_pkg::P_STORE);
                        r_addr  <= r_paddr;
                        r_nb    <= r_pnb;
                        r_d     <= r_pdata;
                        r_way   <= r_pway;
                    end
                end else if (acc && i_cmd == sacc_pkg::CMD_REFILL &&
                             r_pend == sacc_pkg::P_BYPASS) begin
                    r_bfirst <= i_payload;
                    r_rld    <= {16'b0, byp_val};
                    r_rlat   <= r_penalty;
                    r_rerr   <= 1'b0;
                end
            end
            sacc_pkg::S_TAG: begin
                r_row <= t_rdata;
                r_k   <= '0;
                if (!r_fin) begin
                    r_way  <= go_hit ? look.hit_way : look.victim;
                    r_pnb  <= r_nb;
                    r_vtag <= t_rdata[look.victim*sacc_pkg::ENTRY_W +: sacc_pkg::TAG_W];
                end
            end
            sacc_pkg::S_DRD1: r_w0 <= d_rdata;
            sacc_pkg::S_DRD2: r_w1 <= d_rdata;
            sacc_pkg::S_UPD: begin
                r_rld  <= r_store ? 32'd0 : load_val;
                r_rlat <= (!r_store && r_fin) ? r_penalty : 16'd0;
                r_rerr <= 1'b0;
            end
            sacc_pkg::S_WBOUT: if (out_free) r_k <= r_k + 1'b1;
            default: begin
            end
        endcase
    end

    assign o_valid       = r_ov;
    assign o_kind        = r_okind;
    assign o_mem_address = r_oaddr;
    assign o_mem_data    = r_odata;
    assign o_mem_bytes   = r_obytes;
    assign o_load_data   = r_old;
    assign o_latency     = r_olat;
    assign o_error       = r_oerr;
    assign o_last        = r_olast;

endmodule

// ===== rtl/core/sacc_checker.sv =====
// ----------------------------------------------------------------------------
// sacc_checker
// Port-level checks of the cache controller, bound to the top level.
// ----------------------------------------------------------------------------
module sacc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_cmd,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_kind,
    input logic [31:0] o_mem_address,
    input logic [2:0]  o_mem_bytes,
    input logic        o_error,
    input logic        o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_mem_address))
        else $error("stalled transaction changed");

    a_inval_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_cmd == sacc_pkg::CMD_INVAL |=> !o_stall)
        else $error("invalidate left the controller busy");

    a_err_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_kind == sacc_pkg::KIND_RESP && o_last)
        else $error("error flag outside a final response");

    a_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != sacc_pkg::KIND_MEM_WR |-> o_mem_bytes == 3'd0)
        else $error("byte count on a non-write transaction");

    a_wb_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == sacc_pkg::KIND_WB |-> !o_last)
        else $error("write-back word marked final");

endmodule

bind set_assoc_lru_cache_controller_unit sacc_checker u_sacc_checker (.*);
